// File: design/bfa_pkg.sv
// Shared constants, types and helpers for the bitmap frame allocator.
package bfa_pkg;

    localparam int MAX_FRAMES = 32768;
    localparam int WORD_BITS  = 32;
    localparam int PAGE_BYTES = 4096;

    localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
    localparam int ADDR_W     = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int FADDR_W    = FRAME_W + PAGE_SHIFT;
    localparam int CNT_W      = 16;
    localparam int REQ_W      = 2;
    localparam int STS_W      = 2;
    localparam int IN_ADDR_W  = 32;

    localparam logic [CNT_W-1:0] TOTAL_RST    = 16'd32768;
    localparam logic [CNT_W-1:0] RESERVED_RST = 16'd1024;
    localparam logic [CNT_W-1:0] FRAMES_MAX   = CNT_W'(MAX_FRAMES);

    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_NO_FRAME = 2'd1;
    localparam logic [STS_W-1:0] STS_BAD_FREE = 2'd2;

    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } t_find;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] dec_floor(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

endpackage

// File: design/bfa_word_find.sv
// Lowest clear bit finder for one bitmap word.
module bfa_word_find
    import bfa_pkg::*;
(
    input  t_word i_word,
    output t_find o_find
);

    always_comb begin
        o_find = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_find.found   = 1'b1;
                o_find.bit_idx = BIT_W'(i);
            end
        end
    end

endmodule

// File: design/bitmap_frame_allocator.sv
// Bitmap page-frame allocator, first fit, top level.
// The used/free map lives in a 1024 x 32 single-port-write RAM with a registered read,
// and one request is processed at a time. After reset the block runs its init pass over
// all 1024 words, with the input stalled, before taking the first request. An init
// request reruns that pass. Unless the free count is zero, an allocate request scans
// the map one word per cycle and stops at the first word with a clear bit or past the
// active total. A free request does a read, a check and write-back, and the result
// load, or only the result load when the address is out of range. A result held by
// the receiver keeps the block in its done state until the output register frees.
module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [IN_ADDR_W-1:0] i_free_address,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STS_W-1:0]     o_status,
    output logic [FRAME_W-1:0]   o_frame_index,
    output logic [FADDR_W-1:0]   o_frame_address,
    output logic [CNT_W-1:0]     o_used_frames,
    output logic [CNT_W-1:0]     o_free_frames
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FREE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int FR_W = IN_ADDR_W - PAGE_SHIFT;

    t_word                r_map [MAP_WORDS];
    t_word                r_rd_data;

    logic [2:0]           r_state;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_reserved;
    logic [CNT_W-1:0]     r_init_res;
    logic [ADDR_W:0]      r_addr;
    logic [ADDR_W:0]      r_chk_addr;
    logic                 r_chk_vld;
    logic                 r_init_rpt;
    logic [FRAME_W-1:0]   r_free_frame;
    logic [CNT_W-1:0]     r_used;
    logic [CNT_W-1:0]     r_free;
    logic [STS_W-1:0]     r_res_status;
    logic [FRAME_W-1:0]   r_res_index;
    logic                 r_out_vld;
    logic [STS_W-1:0]     r_out_status;
    logic [FRAME_W-1:0]   r_out_index;
    logic [CNT_W-1:0]     r_out_used;
    logic [CNT_W-1:0]     r_out_free;

    logic [CNT_W-1:0]     w_eff_tot;
    logic [CNT_W-1:0]     w_res;
    logic [ADDR_W:0]      w_res_word;
    t_word                w_init_word;
    logic [FR_W-1:0]      w_free_fr;
    logic                 w_free_in_rng;
    logic [CNT_W-1:0]     w_base;
    logic [FRAME_W-1:0]   w_hit_frame;
    logic                 w_base_ok;
    logic                 w_hit_ok;
    logic                 w_free_set;
    logic [BIT_W-1:0]     w_free_bit;
    t_find                w_find;
    logic                 w_mem_we;
    logic [ADDR_W-1:0]    w_mem_waddr;
    logic [ADDR_W-1:0]    w_mem_raddr;
    t_word                w_mem_wdata;

    bfa_word_find u_find (
        .i_word (r_rd_data),
        .o_find (w_find)
    );

    assign w_eff_tot     = (r_total > FRAMES_MAX) ? FRAMES_MAX : r_total;
    assign w_res         = (r_reserved < w_eff_tot) ? r_reserved : w_eff_tot;
    assign w_res_word    = r_init_res[CNT_W-1:BIT_W];
    assign w_free_fr     = i_free_address[IN_ADDR_W-1:PAGE_SHIFT];
    assign w_free_in_rng = w_free_fr < FR_W'(w_eff_tot);
    assign w_base        = {r_chk_addr, {BIT_W{1'b0}}};
    assign w_hit_frame   = {r_chk_addr[ADDR_W-1:0], w_find.bit_idx};
    assign w_base_ok     = w_base < w_eff_tot;
    assign w_hit_ok      = {1'b0, w_hit_frame} < w_eff_tot;
    assign w_free_bit    = r_free_frame[BIT_W-1:0];
    assign w_free_set    = r_rd_data[w_free_bit];

    always_comb begin
        if (r_addr < w_res_word) begin
            w_init_word = '1;
        end else if (r_addr == w_res_word) begin
            w_init_word = ~('1 << r_init_res[BIT_W-1:0]);
        end else begin
            w_init_word = '0;
        end
    end

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr[ADDR_W-1:0];
        w_mem_wdata = w_init_word;
        w_mem_raddr = r_addr[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                w_mem_raddr = w_free_fr[FRAME_W-1:BIT_W];
            end
            S_INIT: begin
                w_mem_we = 1'b1;
            end
            S_SCAN: begin
                w_mem_we    = r_chk_vld && w_base_ok && w_find.found && w_hit_ok;
                w_mem_waddr = r_chk_addr[ADDR_W-1:0];
                w_mem_wdata = r_rd_data | (t_word'(1) << w_find.bit_idx);
            end
            S_FREE: begin
                w_mem_we    = w_free_set;
                w_mem_waddr = r_free_frame[FRAME_W-1:BIT_W];
                w_mem_wdata = r_rd_data & ~(t_word'(1) << w_free_bit);
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_map[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_map[w_mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_total    <= TOTAL_RST;
            r_reserved <= RESERVED_RST;
            r_init_res <= RESERVED_RST;
            r_used     <= RESERVED_RST;
            r_free     <= TOTAL_RST - RESERVED_RST;
            r_addr     <= '0;
            r_chk_vld  <= 1'b0;
            r_init_rpt <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TOTAL:    r_total    <= i_cfg_data;
                    CFG_RESERVED: r_reserved <= i_cfg_data;
                    default:      r_total    <= r_total;
                endcase
            end

            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_res_status <= STS_OK;
                        r_res_index  <= '0;
                        case (i_req_type)
                            REQ_INIT: begin
                                r_init_res <= w_res;
                                r_used     <= w_res;
                                r_free     <= w_eff_tot - w_res;
                                r_addr     <= '0;
                                r_init_rpt <= 1'b1;
                                r_state    <= S_INIT;
                            end
                            REQ_ALLOC: begin
                                if (r_free == '0) begin
                                    r_res_status <= STS_NO_FRAME;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_addr    <= '0;
                                    r_chk_vld <= 1'b0;
                                    r_state   <= S_SCAN;
                                end
                            end
                            REQ_FREE: begin
                                if (w_free_in_rng) begin
                                    r_free_frame <= w_free_fr[FRAME_W-1:0];
                                    r_state      <= S_FREE;
                                end else begin
                                    r_res_status <= STS_BAD_FREE;
                                    r_state      <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr[ADDR_W-1:0] == '1) begin
                        r_init_rpt <= 1'b0;
                        r_state    <= r_init_rpt ? S_DONE : S_IDLE;
                    end
                end
                S_SCAN: begin
                    r_addr     <= r_addr + 1'b1;
                    r_chk_addr <= r_addr;
                    r_chk_vld  <= 1'b1;
                    if (r_chk_vld) begin
                        if (!w_base_ok) begin
                            r_res_status <= STS_NO_FRAME;
                            r_state      <= S_DONE;
                        end else if (w_find.found) begin
                            if (w_hit_ok) begin
                                r_res_index <= w_hit_frame;
                                r_used      <= inc_sat(r_used);
                                r_free      <= dec_floor(r_free);
                            end else begin
                                r_res_status <= STS_NO_FRAME;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_FREE: begin
                    if (w_free_set) begin
                        r_res_index <= r_free_frame;
                        r_used      <= dec_floor(r_used);
                        r_free      <= inc_sat(r_free);
                    end else begin
                        r_res_status <= STS_BAD_FREE;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld    <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_index  <= r_res_index;
                        r_out_used   <= r_used;
                        r_out_free   <= r_free;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_frame_index   = r_out_index;
    assign o_frame_address = {r_out_index, {PAGE_SHIFT{1'b0}}};
    assign o_used_frames   = r_out_used;
    assign o_free_frames   = r_out_free;

endmodule

// File: design/bfa_checker.sv
// Port-level assertions for the bitmap frame allocator, bound to the top level.
module bfa_checker
    import bfa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [STS_W-1:0]     o_status,
    input logic [FRAME_W-1:0]   o_frame_index,
    input logic [FADDR_W-1:0]   o_frame_address,
    input logic [CNT_W-1:0]     o_used_frames,
    input logic [CNT_W-1:0]     o_free_frames
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_frame_index) && $stable(o_used_frames) && $stable(o_free_frames))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STS_OK |-> o_frame_index == '0)
        else $error("failed request reports a frame");

    a_addr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_address == {o_frame_index, {PAGE_SHIFT{1'b0}}})
        else $error("frame address does not match frame index");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == STS_OK || o_status == STS_NO_FRAME
            || o_status == STS_BAD_FREE)
        else $error("unknown status code");

    // map init pass follows reset
    a_reset_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during reset init pass");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);

// File: dv/tb.sv
// Testbench for bitmap_frame_allocator: shadow-map predictor, random traffic, reply scoreboard.
module tb;
    import bfa_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic                 i_cfg_index    = CFG_TOTAL;
    logic [CNT_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic [REQ_W-1:0]     i_req_type     = REQ_INIT;
    logic [IN_ADDR_W-1:0] i_free_address = '0;
    logic                 i_out_stall    = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [STS_W-1:0]     o_status;
    logic [FRAME_W-1:0]   o_frame_index;
    logic [FADDR_W-1:0]   o_frame_address;
    logic [CNT_W-1:0]     o_used_frames;
    logic [CNT_W-1:0]     o_free_frames;

    typedef struct packed {
        logic [STS_W-1:0]   status;
        logic [FRAME_W-1:0] index;
        logic [FADDR_W-1:0] addr;
        logic [CNT_W-1:0]   used;
        logic [CNT_W-1:0]   free;
    } reply_t;

    // shadow allocator state
    logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
    logic [CNT_W-1:0]     used_cnt;
    logic [CNT_W-1:0]     free_cnt;
    logic [CNT_W-1:0]     cfg_total;
    logic [CNT_W-1:0]     cfg_reserved;

    reply_t pending_replies [$];
    reply_t want;

    bit quiet        = 1'b0;
    int hold_request = 0;
    int stall_left   = 0;
    int mismatches   = 0;
    int replies_seen = 0;
    int n_requests   = 0;
    int n_alloc_ok   = 0;
    int n_alloc_fail = 0;
    int n_free_ok    = 0;
    int n_free_bad   = 0;
    int n_inits      = 0;

    bitmap_frame_allocator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_free_address (i_free_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_frame_index  (o_frame_index),
        .o_frame_address(o_frame_address),
        .o_used_frames  (o_used_frames),
        .o_free_frames  (o_free_frames)
    );

    always #2 i_clk = ~i_clk;

    function automatic int active_frames();
        return (cfg_total > MAX_FRAMES) ? MAX_FRAMES : int'(cfg_total);
    endfunction

    function automatic bit frame_marked(input int f);
        return shadow_map[f / WORD_BITS][f % WORD_BITS];
    endfunction

    function automatic void map_init();
        int tot;
        int res;
        tot = active_frames();
        res = (int'(cfg_reserved) < tot) ? int'(cfg_reserved) : tot;
        foreach (shadow_map[w]) shadow_map[w] = '0;
        for (int f = 0; f < res; f++) shadow_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
        used_cnt = CNT_W'(res);
        free_cnt = CNT_W'(tot - res);
    endfunction

    // first fit: lowest clear frame below the active total, -1 if none
    function automatic int lowest_free_frame();
        int tot;
        tot = active_frames();
        for (int w = 0; w * WORD_BITS < tot; w++) begin
            if (shadow_map[w] == '1) continue;
            for (int b = 0; b < WORD_BITS; b++) begin
                if (w * WORD_BITS + b >= tot) return -1;
                if (!shadow_map[w][b]) return w * WORD_BITS + b;
            end
        end
        return -1;
    endfunction

    function automatic void apply_request(input logic [REQ_W-1:0] kind,
                                          input logic [IN_ADDR_W-1:0] addr);
        reply_t r;
        int f;
        logic [IN_ADDR_W-1:0] fr;
        r = '0;
        n_requests++;
        case (kind)
            REQ_INIT: begin
                map_init();
                n_inits++;
            end
            REQ_ALLOC: begin
                f = (free_cnt != '0) ? lowest_free_frame() : -1;
                if (f < 0) begin
                    r.status = STS_NO_FRAME;
                    n_alloc_fail++;
                end else begin
                    shadow_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
                    used_cnt = (used_cnt == '1) ? used_cnt : used_cnt + 1'b1;
                    free_cnt = (free_cnt == '0) ? free_cnt : free_cnt - 1'b1;
                    r.index  = FRAME_W'(f);
                    r.addr   = FADDR_W'(f) << PAGE_SHIFT;
                    n_alloc_ok++;
                end
            end
            REQ_FREE: begin
                fr = addr >> PAGE_SHIFT;
                if (fr >= active_frames() || !frame_marked(int'(fr))) begin
                    r.status = STS_BAD_FREE;
                    n_free_bad++;
                end else begin
                    f = int'(fr);
                    shadow_map[f / WORD_BITS][f % WORD_BITS] = 1'b0;
                    used_cnt = (used_cnt == '0) ? used_cnt : used_cnt - 1'b1;
                    free_cnt = (free_cnt == '1) ? free_cnt : free_cnt + 1'b1;
                    r.index  = FRAME_W'(f);
                    r.addr   = FADDR_W'(f) << PAGE_SHIFT;
                    n_free_ok++;
                end
            end
            default: ;
        endcase
        r.used = used_cnt;
        r.free = free_cnt;
        pending_replies.push_back(r);
    endfunction

    // byte address inside a random used frame below the total, else a random address
    function automatic logic [IN_ADDR_W-1:0] used_frame_address();
        int tot;
        int start;
        int f;
        tot = active_frames();
        if (tot == 0) return $urandom;
        start = $urandom_range(0, tot - 1);
        for (int i = 0; i < tot; i++) begin
            f = (start + i) % tot;
            if (frame_marked(f))
                return (IN_ADDR_W'(f) << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1);
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [IN_ADDR_W-1:0] addr);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= kind;
        i_free_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        apply_request(kind, addr);
    endtask

    // drop valid and wait for every reply
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [CNT_W-1:0] value);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TOTAL) cfg_total = value;
        else cfg_reserved = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (!quiet && i_rst_n && $urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 14);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("reply with no request pending, status %0d",
                                          o_status));
            end else begin
                want = pending_replies.pop_front();
                replies_seen++;
                if (o_status !== want.status)
                    report_mismatch($sformatf("reply %0d status %0h want %0h",
                                              replies_seen, o_status, want.status));
                if (o_frame_index !== want.index)
                    report_mismatch($sformatf("reply %0d frame_index %0h want %0h",
                                              replies_seen, o_frame_index, want.index));
                if (o_frame_address !== want.addr)
                    report_mismatch($sformatf("reply %0d frame_address %0h want %0h",
                                              replies_seen, o_frame_address, want.addr));
                if (o_used_frames !== want.used)
                    report_mismatch($sformatf("reply %0d used_frames %0d want %0d",
                                              replies_seen, o_used_frames, want.used));
                if (o_free_frames !== want.free)
                    report_mismatch($sformatf("reply %0d free_frames %0d want %0d",
                                              replies_seen, o_free_frames, want.free));
            end
        end
    end

    task automatic test_reset_map();
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_FREE, 32'h0000_0FFF);
        send_request(REQ_FREE, 32'h0000_0000);
        send_request(REQ_FREE, 32'hFFFF_FFFF);
        send_request(REQ_FREE, 32'h0800_0000);
        send_request(REQ_FREE, 32'h07FF_F000);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF);
        send_request(REQ_INIT, 32'h0);
    endtask

    // total not a multiple of the word size: search must reach the tail word
    task automatic test_tail_frames();
        write_register(CFG_TOTAL, 16'd45);
        write_register(CFG_RESERVED, 16'd40);
        send_request(REQ_INIT, 32'h0);
        repeat (6) send_request(REQ_ALLOC, $urandom);
        send_request(REQ_FREE, (32'd44 << PAGE_SHIFT) | 32'hFFF);
        send_request(REQ_FREE, 32'd45 << PAGE_SHIFT);
        send_request(REQ_ALLOC, 32'h0);
    endtask

    task automatic test_register_extremes();
        write_register(CFG_TOTAL, 16'd0);
        write_register(CFG_RESERVED, 16'd0);
        send_request(REQ_INIT, 32'h0);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_FREE, 32'h0);
        write_register(CFG_TOTAL, 16'hFFFF);
        write_register(CFG_RESERVED, 16'hFFFF);
        send_request(REQ_INIT, 32'h0);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_FREE, 32'h07FF_F000);
        send_request(REQ_ALLOC, 32'h0);
        write_register(CFG_TOTAL, TOTAL_RST);
        write_register(CFG_RESERVED, 16'd0);
        send_request(REQ_INIT, 32'h0);
        send_request(REQ_ALLOC, 32'h0);
    endtask

    // long receiver hold while requests keep coming
    task automatic test_output_hold();
        hold_request = 300;
        repeat (6) begin
            send_request(REQ_ALLOC, $urandom);
            send_request(REQ_FREE, used_frame_address());
        end
    endtask

    task automatic run_traffic(input logic [CNT_W-1:0] total, input logic [CNT_W-1:0] reserved,
                               input bit reinit, input int count);
        int pick;
        logic [REQ_W-1:0] kind;
        logic [IN_ADDR_W-1:0] addr;
        write_register(CFG_TOTAL, total);
        write_register(CFG_RESERVED, reserved);
        if (reinit) send_request(REQ_INIT, $urandom);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            addr = $urandom;
            if (pick < 4) kind = REQ_INIT;
            else if (pick < 8) kind = REQ_UNUSED;
            else if (pick < 50) kind = REQ_ALLOC;
            else begin
                kind = REQ_FREE;
                if (pick < 88)
                    addr = used_frame_address();
                else if (pick < 94)
                    addr = (IN_ADDR_W'($urandom_range(0, active_frames() + 2)) << PAGE_SHIFT)
                           | $urandom_range(0, PAGE_BYTES - 1);
            end
            send_request(kind, addr);
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(TOTAL_RST, RESERVED_RST, 1'b1, 150);
        run_traffic(16'd64, 16'd8, 1'b1, 150);
        run_traffic(16'd100, 16'd0, 1'b1, 130);
        run_traffic(16'd45, 16'd45, 1'b1, 100);
        run_traffic(16'd200, 16'd300, 1'b1, 100);
        run_traffic(16'd300, 16'd300, 1'b0, 100);
        run_traffic(16'd1, 16'd0, 1'b1, 60);
        run_traffic(16'hFFFF, 16'd32767, 1'b1, 60);
        quiet = 1'b1;
        run_traffic(16'd96, 16'd16, 1'b1, 150);
    endtask

    initial begin
        cfg_total    = TOTAL_RST;
        cfg_reserved = RESERVED_RST;
        map_init();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_map();
        test_tail_frames();
        test_register_extremes();
        test_output_hold();
        test_random_traffic();
        settle_block();
        repeat (40) @(posedge i_clk);
        $display("%0d requests, %0d replies: %0d allocs (%0d refused), %0d frees (%0d rejected)",
                 n_requests, replies_seen, n_alloc_ok + n_alloc_fail, n_alloc_fail,
                 n_free_ok + n_free_bad, n_free_bad);
        $display("%0d map inits; totals 0..65535, reserved 0..65535, long output hold",
                 n_inits);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout, %0d replies still pending", pending_replies.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
